### hw/rtl/assert_macros.svh
// Concurrent assertion macros used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### hw/rtl/bsc_pkg.sv
// Shared types, operation codes and helpers for the compensation block
package bsc_pkg;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD,
      OP_T0, OP_T1, OP_T2, OP_T3, OP_T4,
      OP_P0, OP_P1, OP_P2, OP_P3, OP_P4, OP_P5, OP_P6, OP_P7, OP_P8, OP_P9, OP_P10,
      OP_DIV_INIT, OP_DIV_STEP,
      OP_P12, OP_P13, OP_P14, OP_P15, OP_P16,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_zero;
   } status_type;

   typedef enum logic [1:0] {
      CSR_TEMP_CALIB  = 2'd0,
      CSR_PRESS_LOW   = 2'd1,
      CSR_PRESS_HIGH  = 2'd2,
      CSR_PRESS_LAST  = 2'd3
   } csr_index_type;

   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [31:0] TEMP_OFFSET  = 32'd64000;
   localparam logic [31:0] PRESS_BASE   = 32'd1048576;
   localparam logic [31:0] PRESS_SCALE  = 32'd3125;
   localparam logic [31:0] ROUND_HALF   = 32'd128;
   localparam logic [31:0] DIV_BIAS     = 32'd32768;
   localparam logic [31:0] TEMP_SCALE   = 32'd5;
   localparam logic [31:0] PRESS_MAX    = 32'd262143;

   function automatic logic [31:0] asr(input logic [31:0] x, input int n);
      asr = 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sext16(input logic [15:0] x);
      sext16 = {{16{x[15]}}, x};
   endfunction

endpackage

### hw/rtl/bsc_ctrl.sv
// Sequencing state machine for the compensation block
`include "assert_macros.svh"
module bsc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_action,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bsc_pkg::cmd_type    cmd,
   input  bsc_pkg::status_type status
);
   import bsc_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIV, ST_OUT} state_type;

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_RUN;
               op_in    = req_action ? OP_P0 : OP_T0;
            end
         end
         ST_RUN: begin
            cmd.op = op_ff;
            case (op_ff)
               OP_T0:  op_in = OP_T1;
               OP_T1:  op_in = OP_T2;
               OP_T2:  op_in = OP_T3;
               OP_T3:  op_in = OP_T4;
               OP_T4:  state_in = ST_OUT;
               OP_P0:  op_in = OP_P1;
               OP_P1:  op_in = OP_P2;
               OP_P2:  op_in = OP_P3;
               OP_P3:  op_in = OP_P4;
               OP_P4:  op_in = OP_P5;
               OP_P5:  op_in = OP_P6;
               OP_P6:  op_in = OP_P7;
               OP_P7:  op_in = OP_P8;
               OP_P8:  op_in = OP_P9;
               OP_P9:  op_in = OP_P10;
               OP_P10: begin
                  if (status.div_zero) begin
                     state_in = ST_OUT;
                  end else begin
                     op_in = OP_DIV_INIT;
                  end
               end
               OP_DIV_INIT: begin
                  state_in = ST_DIV;
                  cnt_in   = '0;
               end
               OP_P12: op_in = OP_P13;
               OP_P13: op_in = OP_P14;
               OP_P14: op_in = OP_P15;
               OP_P15: op_in = OP_P16;
               OP_P16: state_in = ST_OUT;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_DIV: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_RUN;
               op_in    = OP_P12;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_NONE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_IMPLIES(a_accept_idle, clock, reset, req_valid && !req_stall,
      state_ff == ST_IDLE, "word accepted while busy")
   `ASSERT_NEXT(a_div_exit, clock, reset,
      state_ff == ST_DIV && cnt_ff == DIV_CNT_W'(DIV_STEPS - 1),
      state_ff == ST_RUN && op_ff == OP_P12, "divide did not finish")
   `ASSERT_NEXT(a_out_valid, clock, reset, cmd.op == OP_OUT,
      rsp_valid_ff && state_ff == ST_IDLE, "result not presented")

endmodule

### hw/rtl/bsc_dp.sv
// Datapath: calibration registers, shared multiplier and restoring divider
module bsc_dp (
   input  logic               clock,
   input  logic               reset,
   input  bsc_pkg::cmd_type     cmd,
   output bsc_pkg::status_type  status,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_write_data,
   input  logic               req_action,
   input  logic [19:0]        req_raw_reading,
   output logic               rsp_is_pressure,
   output logic signed [15:0] rsp_temperature_centi,
   output logic [17:0]        rsp_pressure_pa,
   output logic               rsp_invalid
);
   import bsc_pkg::*;

   logic [47:0] tcal_ff;
   logic [63:0] plo_ff, phi_ff;
   logic [15:0] plast_ff;
   logic [31:0] fine_ff, fine_in;

   logic [19:0] adc_ff, adc_in;
   logic        isp_ff, isp_in, inv_ff, inv_in, big_ff, big_in;
   logic [31:0] ra_ff, ra_in, rb_ff, rb_in, rq_ff, rq_in, rqq_ff, rqq_in;
   logic [31:0] rt_ff, rt_in, rw_ff, rw_in, rp_ff, rp_in, quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in, r2;

   logic        o_isp_ff, o_isp_in, o_inv_ff, o_inv_in;
   logic [15:0] o_temp_ff, o_temp_in;
   logic [17:0] o_press_ff, o_press_in;

   logic [31:0] mul_a, mul_b, prod;
   logic [15:0] t1, p1;
   logic [31:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

   assign t1 = tcal_ff[15:0];
   assign t2 = sext16(tcal_ff[31:16]);
   assign t3 = sext16(tcal_ff[47:32]);
   assign p1 = plo_ff[15:0];
   assign p2 = sext16(plo_ff[31:16]);
   assign p3 = sext16(plo_ff[47:32]);
   assign p4 = sext16(plo_ff[63:48]);
   assign p5 = sext16(phi_ff[15:0]);
   assign p6 = sext16(phi_ff[31:16]);
   assign p7 = sext16(phi_ff[47:32]);
   assign p8 = sext16(phi_ff[63:48]);
   assign p9 = sext16(plast_ff);

   assign prod = 32'(mul_a * mul_b);
   assign r2   = {rem_ff[31:0], quo_ff[31]};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_T0: begin
            mul_a = 32'(adc_ff[19:3]) - {15'b0, t1, 1'b0};
            mul_b = t2;
         end
         OP_T1: begin
            mul_a = 32'(adc_ff[19:4]) - {16'b0, t1};
            mul_b = 32'(adc_ff[19:4]) - {16'b0, t1};
         end
         OP_T2: begin
            mul_a = rb_ff;
            mul_b = t3;
         end
         OP_T4: begin
            mul_a = fine_ff;
            mul_b = TEMP_SCALE;
         end
         OP_P2: begin
            mul_a = rq_ff;
            mul_b = rq_ff;
         end
         OP_P3: begin
            mul_a = asr(rqq_ff, 11);
            mul_b = p6;
         end
         OP_P4: begin
            mul_a = ra_ff;
            mul_b = p5;
         end
         OP_P6: begin
            mul_a = p3;
            mul_b = asr(rqq_ff, 13);
         end
         OP_P7: begin
            mul_a = p2;
            mul_b = ra_ff;
         end
         OP_P9: begin
            mul_a = DIV_BIAS + ra_ff;
            mul_b = {16'b0, p1};
         end
         OP_P10: begin
            mul_a = (PRESS_BASE - 32'(adc_ff)) - asr(rb_ff, 12);
            mul_b = PRESS_SCALE;
         end
         OP_P13: begin
            mul_a = rp_ff >> 3;
            mul_b = rp_ff >> 3;
         end
         OP_P14: begin
            mul_a = p9;
            mul_b = rt_ff;
         end
         OP_P15: begin
            mul_a = rp_ff >> 2;
            mul_b = p8;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      adc_in     = adc_ff;
      isp_in     = isp_ff;
      inv_in     = inv_ff;
      big_in     = big_ff;
      fine_in    = fine_ff;
      ra_in      = ra_ff;
      rb_in      = rb_ff;
      rq_in      = rq_ff;
      rqq_in     = rqq_ff;
      rt_in      = rt_ff;
      rw_in      = rw_ff;
      rp_in      = rp_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      o_isp_in   = o_isp_ff;
      o_inv_in   = o_inv_ff;
      o_temp_in  = o_temp_ff;
      o_press_in = o_press_ff;
      case (cmd.op)
         OP_LOAD: begin
            adc_in = req_raw_reading;
            isp_in = req_action;
            inv_in = 1'b0;
         end
         OP_T0:  ra_in = asr(prod, 11);
         OP_T1:  rb_in = asr(prod, 12);
         OP_T2:  rb_in = asr(prod, 14);
         OP_T3:  fine_in = ra_ff + rb_ff;
         OP_T4:  rt_in = asr(prod + ROUND_HALF, 8);
         OP_P0:  ra_in = asr(fine_ff, 1) - TEMP_OFFSET;
         OP_P1:  rq_in = asr(ra_ff, 2);
         OP_P2:  rqq_in = prod;
         OP_P3:  rb_in = prod;
         OP_P4:  rb_in = rb_ff + (prod << 1);
         OP_P5:  rb_in = asr(rb_ff, 2) + {p4[15:0], 16'b0};
         OP_P6:  rt_in = asr(prod, 3);
         OP_P7:  rt_in = rt_ff + asr(prod, 1);
         OP_P8:  ra_in = asr(rt_ff, 18);
         OP_P9:  ra_in = asr(prod, 15);
         OP_P10: begin
            rp_in  = prod;
            inv_in = (ra_ff == '0);
         end
         OP_DIV_INIT: begin
            big_in = rp_ff[31];
            quo_in = rp_ff[31] ? rp_ff : (rp_ff << 1);
            rem_in = '0;
         end
         OP_DIV_STEP: begin
            if (r2 >= {1'b0, ra_ff}) begin
               rem_in = r2 - {1'b0, ra_ff};
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = r2;
               quo_in = {quo_ff[30:0], 1'b0};
            end
         end
         OP_P12: rp_in = big_ff ? (quo_ff << 1) : quo_ff;
         OP_P13: rt_in = prod >> 13;
         OP_P14: rw_in = asr(prod, 12);
         OP_P15: rw_in = rw_ff + asr(prod, 13);
         OP_P16: rp_in = rp_ff + asr(rw_ff + p7, 4);
         OP_OUT: begin
            o_isp_in   = isp_ff;
            o_inv_in   = isp_ff && inv_ff;
            o_temp_in  = '0;
            o_press_in = '0;
            if (!isp_ff) begin
               if ($signed(rt_ff) > 32'sd32767) begin
                  o_temp_in = 16'h7fff;
               end else if ($signed(rt_ff) < -32'sd32768) begin
                  o_temp_in = 16'h8000;
               end else begin
                  o_temp_in = rt_ff[15:0];
               end
            end else if (!inv_ff) begin
               if (rp_ff[31]) begin
                  o_press_in = '0;
               end else if (rp_ff > PRESS_MAX) begin
                  o_press_in = PRESS_MAX[17:0];
               end else begin
                  o_press_in = rp_ff[17:0];
               end
            end
         end
         default: begin
            adc_in = adc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tcal_ff  <= '0;
         plo_ff   <= '0;
         phi_ff   <= '0;
         plast_ff <= '0;
         fine_ff  <= '0;
      end else begin
         fine_ff <= fine_in;
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_TEMP_CALIB: tcal_ff  <= csr_write_data[47:0];
               CSR_PRESS_LOW:  plo_ff   <= csr_write_data;
               CSR_PRESS_HIGH: phi_ff   <= csr_write_data;
               CSR_PRESS_LAST: plast_ff <= csr_write_data[15:0];
               default:        plast_ff <= plast_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      adc_ff     <= adc_in;
      isp_ff     <= isp_in;
      inv_ff     <= inv_in;
      big_ff     <= big_in;
      ra_ff      <= ra_in;
      rb_ff      <= rb_in;
      rq_ff      <= rq_in;
      rqq_ff     <= rqq_in;
      rt_ff      <= rt_in;
      rw_ff      <= rw_in;
      rp_ff      <= rp_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      o_isp_ff   <= o_isp_in;
      o_inv_ff   <= o_inv_in;
      o_temp_ff  <= o_temp_in;
      o_press_ff <= o_press_in;
   end

   assign status.div_zero       = (ra_ff == '0);
   assign rsp_is_pressure       = o_isp_ff;
   assign rsp_invalid           = o_inv_ff;
   assign rsp_temperature_centi = o_temp_ff;
   assign rsp_pressure_pa       = o_press_ff;

endmodule

### hw/rtl/barometric_sensor_compensation.sv
// Top level of the barometric temperature and pressure compensation block
//
// Request channel (req_*): one word per raw reading, req_action selects
// temperature (0) or pressure (1). A word is taken when req_valid is high
// and req_stall is low; req_stall stays high while a word is in work.
// Response channel (rsp_*): one word per request, held in an output
// register until the receiver takes it with rsp_stall low.
// Configuration (csr_*): calibration words written by index; the user must
// write them only while idle, which the block itself does not enforce.
// A temperature reading runs T0 to T4; a pressure reading runs P0 to P10,
// the 32-step restoring divider and P12 to P16, or goes to the output
// after P10 when the divisor is zero. Products come from the single shared
// 32x32 multiplier. One reading is in work at a time; a new word is taken
// in the cycle after the result is loaded into the output register.
// A stalled receiver holds the output word; once the next result is
// ready the block waits until the pending word is taken.
// Reset clears calibration, fine temperature and the handshake state.
module barometric_sensor_compensation (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [19:0]        req_raw_reading,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_is_pressure,
   output logic signed [15:0] rsp_temperature_centi,
   output logic [17:0]        rsp_pressure_pa,
   output logic               rsp_invalid,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_write_data
);
   import bsc_pkg::*;

   cmd_type    cmd;
   status_type status;

   bsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .status     (status)
   );

   bsc_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .req_action            (req_action),
      .req_raw_reading       (req_raw_reading),
      .rsp_is_pressure       (rsp_is_pressure),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_pressure_pa       (rsp_pressure_pa),
      .rsp_invalid           (rsp_invalid)
   );

endmodule

### verif/barometric_sensor_compensation_test.sv
// Self-checking testbench for the barometric temperature and pressure compensation block
`timescale 1ns / 100ps

typedef struct {
   logic             is_pressure;
   logic signed [15:0] temperature_centi;
   logic [17:0]      pressure_pa;
   logic             invalid;
} reading_result_type;

class compensation_scoreboard;
   logic [47:0] temp_calib;
   logic [63:0] press_low;
   logic [63:0] press_high;
   logic [15:0] press_last;
   logic [31:0] fine_temp;
   reading_result_type pending[$];
   int errors;

   function new();
      temp_calib = '0;
      press_low = '0;
      press_high = '0;
      press_last = '0;
      fine_temp = '0;
      errors = 0;
   endfunction

   function void write_reg(bsc_pkg::csr_index_type idx, logic [63:0] data);
      case (idx)
         bsc_pkg::CSR_TEMP_CALIB: temp_calib = data[47:0];
         bsc_pkg::CSR_PRESS_LOW: press_low = data;
         bsc_pkg::CSR_PRESS_HIGH: press_high = data;
         bsc_pkg::CSR_PRESS_LAST: press_last = data[15:0];
         default: press_last = press_last;
      endcase
   endfunction

   function logic [31:0] sra(logic [31:0] x, int n);
      return 32'($signed(x) >>> n);
   endfunction

   function logic [31:0] sx(logic [15:0] x);
      return {{16{x[15]}}, x};
   endfunction

   function void note_reading(logic action, logic [19:0] raw);
      reading_result_type r;
      logic [31:0] adc, t1, t2, t3, a, d, b;
      logic [31:0] v1, v2, q, p, w1, w2;
      logic signed [31:0] s;
      adc = {12'd0, raw};
      r.is_pressure = action;
      r.temperature_centi = '0;
      r.pressure_pa = '0;
      r.invalid = 1'b0;
      if (!action) begin
         t1 = {16'd0, temp_calib[15:0]};
         t2 = sx(temp_calib[31:16]);
         t3 = sx(temp_calib[47:32]);
         a = sra(((adc >> 3) - (t1 << 1)) * t2, 11);
         d = (adc >> 4) - t1;
         b = sra(sra(d * d, 12) * t3, 14);
         fine_temp = a + b;
         s = $signed(sra(fine_temp * 32'd5 + 32'd128, 8));
         if (s > 32767) s = 32767;
         if (s < -32768) s = -32768;
         r.temperature_centi = s[15:0];
      end else begin
         v1 = sra(fine_temp, 1) - 32'd64000;
         q = sra(v1, 2);
         v2 = sra(q * q, 11) * sx(press_high[31:16]);
         v2 = v2 + ((v1 * sx(press_high[15:0])) << 1);
         v2 = sra(v2, 2) + (sx(press_low[63:48]) << 16);
         v1 = sra(sra(sx(press_low[47:32]) * sra(q * q, 13), 3)
                  + sra(sx(press_low[31:16]) * v1, 1), 18);
         v1 = sra((32'd32768 + v1) * {16'd0, press_low[15:0]}, 15);
         if (v1 == 0) begin
            r.invalid = 1'b1;
         end else begin
            p = ((32'd1048576 - adc) - sra(v2, 12)) * 32'd3125;
            if (p < 32'h8000_0000) p = (p << 1) / v1;
            else p = (p / v1) * 32'd2;
            w1 = sra(sx(press_last) * (((p >> 3) * (p >> 3)) >> 13), 12);
            w2 = sra((p >> 2) * sx(press_high[63:48]), 13);
            p = p + sra(w1 + w2 + sx(press_high[47:32]), 4);
            s = $signed(p);
            if (s < 0) s = 0;
            if (s > 262143) s = 262143;
            r.pressure_pa = s[17:0];
         end
      end
      pending.push_back(r);
   endfunction

   function void report(string what);
      $display("mismatch: %s", what);
      errors++;
   endfunction

   function void check_word(reading_result_type got);
      reading_result_type e;
      if (pending.size() == 0) begin
         report("unexpected result word");
         return;
      end
      e = pending.pop_front();
      if (got.is_pressure !== e.is_pressure)
         report($sformatf("is_pressure got %0d want %0d", got.is_pressure, e.is_pressure));
      if (got.temperature_centi !== e.temperature_centi)
         report($sformatf("temperature got %0d want %0d",
                          got.temperature_centi, e.temperature_centi));
      if (got.pressure_pa !== e.pressure_pa)
         report($sformatf("pressure got %0d want %0d", got.pressure_pa, e.pressure_pa));
      if (got.invalid !== e.invalid)
         report($sformatf("invalid got %0d want %0d", got.invalid, e.invalid));
   endfunction
endclass

module barometric_sensor_compensation_test;
   import bsc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_action = 1'b0;
   logic [19:0] req_raw_reading = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_is_pressure;
   logic signed [15:0] rsp_temperature_centi;
   logic [17:0] rsp_pressure_pa;
   logic rsp_invalid;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = '0;
   logic [63:0] csr_write_data = '0;

   compensation_scoreboard board = new();
   int cycle_count = 0;

   localparam int CYCLE_LIMIT = 1_000_000;

   barometric_sensor_compensation dut (.*);

   always #4 clock = ~clock;

   function automatic int gap_length();
      int k;
      k = $urandom_range(0, 99);
      if (k < 45) return 0;
      if (k < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 70);
   endfunction

   always @(posedge clock) begin
      reading_result_type w;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         w.is_pressure = rsp_is_pressure;
         w.temperature_centi = rsp_temperature_centi;
         w.pressure_pa = rsp_pressure_pa;
         w.invalid = rsp_invalid;
         board.check_word(w);
      end
   end

   // receiver stall pattern, quiet during calm stretches
   initial begin
      int n;
      @(negedge clock);
      forever begin
         n = (cycle_count / 4000) % 3 == 0 ? 0 : gap_length();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   end

   task automatic write_csr(csr_index_type idx, logic [63:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      board.write_reg(idx, data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_reading(logic action, logic [19:0] raw, bit no_gap);
      int n;
      n = no_gap ? 0 : gap_length();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_raw_reading <= raw;
      do @(posedge clock); while (req_stall);
      board.note_reading(action, raw);
      @(negedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   // plausible calibration near a real part, with random jitter
   task automatic load_typical();
      write_csr(CSR_TEMP_CALIB, 64'({16'hFC18 + 16'($urandom_range(0, 63)),
                                     16'd26435 + 16'($urandom_range(0, 511)),
                                     16'd27504 + 16'($urandom_range(0, 1023))}));
      write_csr(CSR_PRESS_LOW, {16'd2855, 16'hD0D0, 16'hD6D0 + 16'($urandom_range(0, 255)),
                                16'd36477 + 16'($urandom_range(0, 511))});
      write_csr(CSR_PRESS_HIGH, {16'hC0AC, 16'd15500, 16'hFFF9, 16'd140});
      write_csr(CSR_PRESS_LAST, 64'd6000);
   endtask

   task automatic load_random();
      write_csr(CSR_TEMP_CALIB, {$urandom(), $urandom()});
      write_csr(CSR_PRESS_LOW, {$urandom(), $urandom()});
      write_csr(CSR_PRESS_HIGH, {$urandom(), $urandom()});
      write_csr(CSR_PRESS_LAST, {$urandom(), $urandom()});
   endtask

   initial begin
      logic [19:0] raw;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // pressure before any temperature, all calibration zero: divisor zero
      send_reading(1'b1, 20'h80000, 1'b1);
      send_reading(1'b0, 20'h00000, 1'b1);
      send_reading(1'b0, 20'hFFFFF, 1'b0);
      drain();

      load_typical();
      send_reading(1'b1, 20'h65A00, 1'b1);
      send_reading(1'b0, 20'h7E000, 1'b1);
      send_reading(1'b1, 20'h65A00, 1'b1);
      send_reading(1'b1, 20'h00000, 1'b0);
      send_reading(1'b1, 20'hFFFFF, 1'b0);
      send_reading(1'b0, 20'h00000, 1'b0);
      send_reading(1'b1, 20'h55555, 1'b0);
      send_reading(1'b0, 20'hFFFFF, 1'b0);
      send_reading(1'b1, 20'hAAAAA, 1'b0);
      drain();

      // extremes: all ones, then signed minimum patterns
      write_csr(CSR_TEMP_CALIB, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_PRESS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_PRESS_LAST, 64'hFFFF_FFFF_FFFF_FFFF);
      send_reading(1'b0, 20'hFFFFF, 1'b0);
      send_reading(1'b1, 20'h00000, 1'b0);
      send_reading(1'b0, 20'h00000, 1'b0);
      send_reading(1'b1, 20'hFFFFF, 1'b0);
      drain();
      write_csr(CSR_TEMP_CALIB, 64'h8000_8000_0000);
      write_csr(CSR_PRESS_LOW, 64'h8000_8000_8000_FFFF);
      write_csr(CSR_PRESS_HIGH, 64'h7FFF_8000_7FFF_8000);
      write_csr(CSR_PRESS_LAST, 64'h8000);
      send_reading(1'b0, 20'h12345, 1'b0);
      send_reading(1'b1, 20'h00001, 1'b0);
      send_reading(1'b0, 20'hFFFFF, 1'b0);
      send_reading(1'b1, 20'hFFFFE, 1'b0);
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         if (phase % 3 == 2) load_random();
         else load_typical();
         for (int i = 0; i < 125; i++) begin
            if (phase % 3 == 2 || $urandom_range(0, 9) == 0) raw = 20'($urandom());
            else raw = 20'h60000 + 20'($urandom_range(0, 20'h2FFFF));
            send_reading(1'($urandom_range(0, 2) != 0), raw, (phase % 4) == 1);
         end
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
